FILE: rtl/core/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

   localparam int FIELD_WIDTH = 32;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_REDUCE = 4'b0010,
      ST_LOOP   = 4'b0100,
      ST_FINISH = 4'b1000
   } mexp_state_type;

endpackage

FILE: rtl/core/modular_exponentiation.sv
// Modular exponentiation core: base to the power of exponent modulo modulus, bit-serial.
//
// Each request carries a base, an exponent and a modulus and gives one response with
// base^exponent mod modulus and an error flag. Operands are taken at WIDTH bits, with
// higher bits ignored. A zero modulus gives 0 with mod_error set, and a zero exponent
// gives 1, not reduced. One request is worked on at a time. The base is first reduced
// modulo the modulus. Then each exponent bit, from the low end up to the highest set bit,
// is handled by the multiply and the square running side by side, each a shift-and-add
// modular multiplier that consumes one bit of the current base per cycle. A request with
// a zero modulus or a zero exponent skips the reduction and the loop and goes straight to
// the finish state. The next request is accepted once the previous result has moved to
// the response register.
module modular_exponentiation #(
   parameter int WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // base_value [31:0], exponent [63:32], modulus [95:64]
   input  logic [3*mexp_pkg::FIELD_WIDTH-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // power_result [31:0]
   output logic [mexp_pkg::FIELD_WIDTH-1:0]     rsp_tdata,
   // mod_error [0]
   output logic                                 rsp_tuser
);
   import mexp_pkg::*;

   localparam int CW = $clog2(WIDTH);
   localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

   // One step of the shift-and-add modular multiplier: (2*acc + bit*a) mod m, with acc
   // and a below m. The sum stays below 3m, so one of three candidates is the answer.
   function automatic logic [WIDTH-1:0] mod_step(input logic [WIDTH-1:0] acc,
                                                 input logic [WIDTH-1:0] a,
                                                 input logic             bit_val,
                                                 input logic [WIDTH-1:0] m);
      logic [WIDTH+1:0] t;
      logic [WIDTH+1:0] d1;
      logic [WIDTH+1:0] d2;
      t  = {1'b0, acc, 1'b0} + (bit_val ? {2'b00, a} : '0);
      d1 = t - {2'b00, m};
      d2 = t - {1'b0, m, 1'b0};
      if (!d2[WIDTH+1]) begin
         return d2[WIDTH-1:0];
      end else if (!d1[WIDTH+1]) begin
         return d1[WIDTH-1:0];
      end
      return t[WIDTH-1:0];
   endfunction

   mexp_state_type   state_ff, state_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] e_ff, e_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] bs_ff, bs_in;
   logic [WIDTH-1:0] r_ff, r_in;
   logic [WIDTH-1:0] accr_ff, accr_in;
   logic [WIDTH-1:0] accs_ff, accs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             err_ff, err_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_err_ff, rsp_err_in;

   logic [WIDTH-1:0] in_b;
   logic [WIDTH-1:0] in_e;
   logic [WIDTH-1:0] in_m;
   logic [WIDTH-1:0] step_r;
   logic [WIDTH-1:0] step_s;
   logic [WIDTH-1:0] e_next;
   logic [WIDTH-1:0] one_w;
   logic             cur_bit;
   logic             req_take;
   logic             out_free;

   assign in_b = WIDTH'(req_tdata[FIELD_WIDTH-1:0]);
   assign in_e = WIDTH'(req_tdata[2*FIELD_WIDTH-1:FIELD_WIDTH]);
   assign in_m = WIDTH'(req_tdata[3*FIELD_WIDTH-1:2*FIELD_WIDTH]);
   assign one_w = WIDTH'(1);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign cur_bit = bs_ff[WIDTH-1];
   assign e_next  = e_ff >> 1;

   // During the base reduction the square unit computes base mod m as base * 1 mod m.
   assign step_r = mod_step(accr_ff, r_ff, cur_bit, m_ff);
   assign step_s = mod_step(accs_ff, (state_ff == ST_REDUCE) ? one_w : b_ff, cur_bit, m_ff);

   always_comb begin
      state_in     = state_ff;
      m_in         = m_ff;
      e_in         = e_ff;
      b_in         = b_ff;
      bs_in        = bs_ff;
      r_in         = r_ff;
      accr_in      = accr_ff;
      accs_in      = accs_ff;
      cnt_in       = cnt_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               m_in    = in_m;
               e_in    = in_e;
               bs_in   = in_b;
               accr_in = '0;
               accs_in = '0;
               cnt_in  = CNT_LAST;
               err_in  = 1'b0;
               if (in_m == '0) begin
                  r_in     = '0;
                  err_in   = 1'b1;
                  state_in = ST_FINISH;
               end else if (in_e == '0) begin
                  r_in     = one_w;
                  state_in = ST_FINISH;
               end else begin
                  // A modulus of one reduces the initial result to zero.
                  r_in     = (in_m == one_w) ? '0 : one_w;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            accs_in = step_s;
            bs_in   = bs_ff << 1;
            cnt_in  = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               b_in     = step_s;
               bs_in    = step_s;
               accs_in  = '0;
               accr_in  = '0;
               cnt_in   = CNT_LAST;
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            accr_in = step_r;
            accs_in = step_s;
            bs_in   = bs_ff << 1;
            cnt_in  = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               if (e_ff[0]) begin
                  r_in = step_r;
               end
               b_in    = step_s;
               bs_in   = step_s;
               e_in    = e_next;
               accr_in = '0;
               accs_in = '0;
               cnt_in  = CNT_LAST;
               if (e_next == '0) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = FIELD_WIDTH'(r_ff);
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      e_ff        <= e_in;
      b_ff        <= b_in;
      bs_ff       <= bs_in;
      r_ff        <= r_in;
      accr_ff     <= accr_in;
      accs_ff     <= accs_in;
      cnt_ff      <= cnt_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule
